>>> rtl/core/wsp_pkg.sv
// Shared types and constants for the WAV stream parser.
package wsp_pkg;

    localparam logic [3:0] PH_RIFF_TAG  = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
    localparam logic [3:0] PH_WAVE_TAG  = 4'd2;
    localparam logic [3:0] PH_CHUNK_ID  = 4'd3;
    localparam logic [3:0] PH_SIZE_FMT  = 4'd4;
    localparam logic [3:0] PH_SIZE_DATA = 4'd5;
    localparam logic [3:0] PH_SIZE_SKIP = 4'd6;
    localparam logic [3:0] PH_FMT_BODY  = 4'd7;
    localparam logic [3:0] PH_DATA_BODY = 4'd8;
    localparam logic [3:0] PH_SKIP_BODY = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    localparam logic [2:0] FMT_U8      = 3'd0;
    localparam logic [2:0] FMT_I16     = 3'd1;
    localparam logic [2:0] FMT_I24     = 3'd2;
    localparam logic [2:0] FMT_I32     = 3'd3;
    localparam logic [2:0] FMT_F32     = 3'd4;
    localparam logic [2:0] FMT_UNKNOWN = 3'd5;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NOT_RIFF = 2'd1;
    localparam logic [1:0] ERR_NOT_WAVE = 2'd2;
    localparam logic [1:0] ERR_UNSUPP   = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [32:0] POS_MAX  = 33'h1_FFFF_FFFF;

    localparam int QDEPTH = 2;

    // One result request, fully formed by the front part.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample_value;
        logic [2:0]  sample_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [1:0]  error_code;
        logic        end_of_file;
    } wsp_res_t;

    // Map format tag and width to a sample format code.
    function automatic logic [2:0] classify(input logic [15:0] tag, input logic [15:0] bits);
        logic [2:0] f;
        f = FMT_UNKNOWN;
        if (tag == 16'h0001)
        begin
            if (bits == 16'd8) f = FMT_U8;
            else if (bits == 16'd16) f = FMT_I16;
            else if (bits == 16'd24) f = FMT_I24;
            else if (bits == 16'd32) f = FMT_I32;
        end
        else if (tag == 16'h0003 && bits == 16'd32)
        begin
            f = FMT_F32;
        end
        return f;
    endfunction

endpackage

>>> rtl/core/wav_stream_parser.sv
// Top level of the byte-serial WAV stream parser.
// Takes one byte of a WAV file per cycle and gives at most one result per byte: a format
// result after the first 16 fmt body bytes, one sample per completed data sample, an end
// marker or an error. Each result is registered in a two-entry queue before it leaves;
// bytes flow as long as the queue has room, so the sustained rate is one byte per cycle.
module wav_stream_parser
    import wsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               start_of_file,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [31:0] sample_value,
    output logic [2:0]         sample_format,
    output logic [15:0]        channel_count,
    output logic [31:0]        sample_rate,
    output logic [1:0]         error_code,
    output logic               end_of_file
);

    logic     has_room, in_fire, res_valid;
    wsp_res_t res, q_out;

    assign in_stall = !has_room;
    assign in_fire = in_valid && has_room;

    wsp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .data_byte(data_byte),
        .start_of_file(start_of_file), .res_valid(res_valid), .res(res)
    );

    wsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res),
        .has_room(has_room), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(q_out)
    );

    // Unpack the result request onto the output ports.
    assign kind = q_out.kind;
    assign sample_value = q_out.sample_value;
    assign sample_format = q_out.sample_format;
    assign channel_count = q_out.channel_count;
    assign sample_rate = q_out.sample_rate;
    assign error_code = q_out.error_code;
    assign end_of_file = q_out.end_of_file;

endmodule

>>> rtl/core/wsp_front.sv
// Front part: walks the RIFF chunk structure and forms result requests.
module wsp_front
    import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        res_valid,
    output wsp_res_t    res
);

    logic [3:0]  phase_reg, phase_next;
    logic [4:0]  fcnt_reg, fcnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [32:0] riff_end_reg, riff_end_next;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [2:0]  fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  sidx_reg, sidx_next;

    // Values seen by this byte after an optional restart.
    logic [3:0]  ph;
    logic [4:0]  fc;
    logic [32:0] re, po;
    logic [2:0]  cf;
    logic [15:0] ch;
    logic [31:0] rt;
    logic [31:0] acc_in;
    logic [1:0]  sbi;
    logic [4:0]  fc1;
    logic [31:0] left1;
    logic [31:0] acc_or;
    logic [2:0]  need;
    logic [2:0]  sidx1;
    logic [31:0] sval;
    logic        at_end;

    // Next-state logic for one byte.
    always_comb
    begin
        ph = start_of_file ? PH_RIFF_TAG : phase_reg;
        fc = start_of_file ? 5'd0 : fcnt_reg;
        re = start_of_file ? 33'd0 : riff_end_reg;
        po = start_of_file ? 33'd0 : pos_reg;
        cf = start_of_file ? FMT_UNKNOWN : fmt_reg;
        ch = start_of_file ? 16'd0 : chan_reg;
        rt = start_of_file ? 32'd0 : rate_reg;
        acc_in = start_of_file ? 32'd0 : acc_reg;
        sbi = start_of_file ? 2'd0 : sidx_reg[1:0];

        phase_next = ph;
        fcnt_next = fc;
        shift_next = start_of_file ? 32'd0 : shift_reg;
        riff_end_next = re;
        pos_next = po;
        left_next = start_of_file ? 32'd0 : left_reg;
        ftag_next = start_of_file ? 16'd0 : ftag_reg;
        fmt_next = cf;
        chan_next = ch;
        rate_next = rt;
        acc_next = acc_in;
        sidx_next = start_of_file ? 3'd0 : sidx_reg;

        res_valid = 1'b0;
        res = '0;
        fc1 = fc + 5'd1;
        left1 = left_next - 32'd1;
        acc_or = acc_in | ({24'd0, data_byte} << {sbi, 3'b000});
        sidx1 = {1'b0, sbi} + 3'd1;
        unique case (cf)
            FMT_U8:  need = 3'd1;
            FMT_I16: need = 3'd2;
            FMT_I24: need = 3'd3;
            default: need = 3'd4;
        endcase
        unique case (cf)
            FMT_U8:  sval = {24'd0, acc_or[7:0]} - 32'd128;
            FMT_I16: sval = {{16{acc_or[15]}}, acc_or[15:0]};
            FMT_I24: sval = {{8{acc_or[23]}}, acc_or[23:0]};
            default: sval = acc_or;
        endcase
        at_end = 1'b0;

        if (in_fire && ph != PH_DONE)
        begin
            if (po != POS_MAX)
                pos_next = po + 33'd1;
            shift_next = {data_byte, shift_next[31:8]};
            at_end = (pos_next >= re);
            res.kind = KIND_END;
            res.error_code = ERR_NONE;
            unique case (ph)
                PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID:
                begin
                    fcnt_next = fc1;
                    if (fc1 >= 5'd4)
                    begin
                        fcnt_next = 5'd0;
                        if (ph == PH_RIFF_TAG)
                        begin
                            if (shift_next != TAG_RIFF)
                            begin
                                phase_next = PH_DONE;
                                res_valid = 1'b1;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_NOT_RIFF;
                            end
                            else
                                phase_next = PH_RIFF_SIZE;
                        end
                        else if (ph == PH_RIFF_SIZE)
                        begin
                            riff_end_next = {1'b0, shift_next} + 33'd8;
                            phase_next = PH_WAVE_TAG;
                        end
                        else if (ph == PH_WAVE_TAG)
                        begin
                            if (shift_next != TAG_WAVE)
                            begin
                                phase_next = PH_DONE;
                                res_valid = 1'b1;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_NOT_WAVE;
                            end
                            else if (at_end)
                            begin
                                phase_next = PH_DONE;
                                res_valid = 1'b1;
                                res.end_of_file = 1'b1;
                            end
                            else
                                phase_next = PH_CHUNK_ID;
                        end
                        else
                            phase_next = (shift_next == TAG_FMT) ? PH_SIZE_FMT :
                                         (shift_next == TAG_DATA) ? PH_SIZE_DATA :
                                         PH_SIZE_SKIP;
                    end
                end
                PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_SKIP:
                begin
                    fcnt_next = fc1;
                    if (fc1 >= 5'd4)
                    begin
                        fcnt_next = 5'd0;
                        left_next = shift_next;
                        if (ph == PH_SIZE_FMT)
                        begin
                            if (shift_next < 32'd16)
                            begin
                                phase_next = PH_DONE;
                                res_valid = 1'b1;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_UNSUPP;
                            end
                            else
                                phase_next = PH_FMT_BODY;
                        end
                        else if (ph == PH_SIZE_DATA && cf == FMT_UNKNOWN)
                        begin
                            phase_next = PH_DONE;
                            res_valid = 1'b1;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_UNSUPP;
                        end
                        else
                        begin
                            if (ph == PH_SIZE_DATA)
                            begin
                                acc_next = 32'd0;
                                sidx_next = 3'd0;
                            end
                            if (shift_next == 32'd0)
                            begin
                                if (at_end)
                                begin
                                    phase_next = PH_DONE;
                                    res_valid = 1'b1;
                                    res.end_of_file = 1'b1;
                                end
                                else
                                    phase_next = PH_CHUNK_ID;
                            end
                            else
                                phase_next = (ph == PH_SIZE_DATA) ? PH_DATA_BODY
                                                                  : PH_SKIP_BODY;
                        end
                    end
                end
                PH_FMT_BODY:
                begin
                    left_next = left1;
                    fcnt_next = fc1;
                    if (fc1 == 5'd2)
                        ftag_next = shift_next[31:16];
                    else if (fc1 == 5'd4)
                        chan_next = shift_next[31:16];
                    else if (fc1 == 5'd8)
                        rate_next = shift_next;
                    else if (fc1 >= 5'd16)
                    begin
                        fcnt_next = 5'd0;
                        fmt_next = classify(ftag_next, shift_next[31:16]);
                        res_valid = 1'b1;
                        if (fmt_next == FMT_UNKNOWN)
                        begin
                            phase_next = PH_DONE;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_UNSUPP;
                        end
                        else
                        begin
                            res.kind = KIND_FORMAT;
                            if (left1 == 32'd0)
                            begin
                                phase_next = at_end ? PH_DONE : PH_CHUNK_ID;
                                res.end_of_file = at_end;
                            end
                            else
                                phase_next = PH_SKIP_BODY;
                        end
                    end
                end
                PH_DATA_BODY:
                begin
                    left_next = left1;
                    acc_next = acc_or;
                    sidx_next = sidx1;
                    if (sidx1 >= need)
                    begin
                        res_valid = 1'b1;
                        res.kind = KIND_SAMPLE;
                        res.sample_value = sval;
                        acc_next = 32'd0;
                        sidx_next = 3'd0;
                    end
                    if (left1 == 32'd0)
                    begin
                        fcnt_next = 5'd0;
                        phase_next = at_end ? PH_DONE : PH_CHUNK_ID;
                        if (at_end)
                        begin
                            res_valid = 1'b1;
                            res.end_of_file = 1'b1;
                        end
                    end
                end
                PH_SKIP_BODY:
                begin
                    left_next = left1;
                    if (left1 == 32'd0)
                    begin
                        fcnt_next = 5'd0;
                        phase_next = at_end ? PH_DONE : PH_CHUNK_ID;
                        if (at_end)
                        begin
                            res_valid = 1'b1;
                            res.end_of_file = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            res.sample_format = fmt_next;
            res.channel_count = chan_next;
            res.sample_rate = rate_next;
        end
        if (!in_fire)
        begin
            phase_next = phase_reg;
            fcnt_next = fcnt_reg;
            shift_next = shift_reg;
            riff_end_next = riff_end_reg;
            pos_next = pos_reg;
            left_next = left_reg;
            ftag_next = ftag_reg;
            fmt_next = fmt_reg;
            chan_next = chan_reg;
            rate_next = rate_reg;
            acc_next = acc_reg;
            sidx_next = sidx_reg;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF_TAG;
            fcnt_reg <= 5'd0;
            shift_reg <= 32'd0;
            riff_end_reg <= 33'd0;
            pos_reg <= 33'd0;
            left_reg <= 32'd0;
            ftag_reg <= 16'd0;
            fmt_reg <= FMT_UNKNOWN;
            chan_reg <= 16'd0;
            rate_reg <= 32'd0;
            acc_reg <= 32'd0;
            sidx_reg <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fcnt_reg <= fcnt_next;
            shift_reg <= shift_next;
            riff_end_reg <= riff_end_next;
            pos_reg <= pos_next;
            left_reg <= left_next;
            ftag_reg <= ftag_next;
            fmt_reg <= fmt_next;
            chan_reg <= chan_next;
            rate_reg <= rate_next;
            acc_reg <= acc_next;
            sidx_reg <= sidx_next;
        end
    end

endmodule

>>> rtl/core/wsp_queue.sv
// Back part: short result queue that drives the output channel.
module wsp_queue
    import wsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  wsp_res_t push_data,
    output logic     has_room,
    output logic     out_valid,
    input  logic     out_stall,
    output wsp_res_t out_data
);

    wsp_res_t   mem_reg [QDEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign has_room = (cnt_reg != 2'(QDEPTH));
    assign pop = out_valid && !out_stall;
    assign out_data = mem_reg[rptr_reg];

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
